### rtl/core/mp2_pkg.sv
// types, constants and helpers shared by the 2x2 max pooling block
`timescale 1ns / 1ps
package mp2_pkg;

	localparam int DATA_BITS  = 32;
	localparam int MAX_COLS   = 64;
	localparam int LINE_DEPTH = MAX_COLS / 2;
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int IDX_W      = $clog2(LINE_DEPTH);
	localparam int DIM_W      = 7;
	localparam int PLANE_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_PLANES = 2'd2;

	typedef logic signed [DATA_BITS-1:0] data_t;

	// position of the pixel being accepted within the plane set
	typedef struct packed {
		logic             active;
		logic             odd_col;
		logic             odd_row;
		logic [IDX_W-1:0] idx;
		logic             plane_end;
		logic             all_end;
	} pos_t;

	function automatic data_t smax(input data_t a, input data_t b);
		return (a >= b) ? a : b;
	endfunction

endpackage

### rtl/core/mp2_pos.sv
// configuration registers and raster position counters
`timescale 1ns / 1ps
module mp2_pos (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mp2_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mp2_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          advance,
	output mp2_pkg::pos_t                  pos
);
	import mp2_pkg::*;

	logic [DIM_W-1:0]   cols_q, rows_q;
	logic [PLANE_W-1:0] planes_q;
	logic [COL_W-1:0]   col_q, row_q;
	logic [PLANE_W-1:0] plane_q;

	logic [DIM_W-1:0]   cols_eff, rows_eff;
	logic [PLANE_W-1:0] planes_eff;
	logic [COL_W-1:0]   cpairs, rpairs;
	logic               col_wrap, row_wrap, plane_wrap;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v < DIM_W'(2))
			return DIM_W'(2);
		else if (v > DIM_W'(MAX_COLS))
			return DIM_W'(MAX_COLS);
		else
			return v;
	endfunction

	always_comb begin
		cols_eff   = clamp_dim(cols_q);
		rows_eff   = clamp_dim(rows_q);
		planes_eff = (planes_q == '0) ? PLANE_W'(1) : planes_q;
		cpairs     = cols_eff[DIM_W-1:1];
		rpairs     = rows_eff[DIM_W-1:1];
		col_wrap   = ({1'b0, col_q} + DIM_W'(1)) >= cols_eff;
		row_wrap   = ({1'b0, row_q} + DIM_W'(1)) >= rows_eff;
		plane_wrap = ({1'b0, plane_q} + (PLANE_W+1)'(1)) >= {1'b0, planes_eff};

		pos.active    = ({1'b0, col_q} < {cpairs, 1'b0}) && ({1'b0, row_q} < {rpairs, 1'b0});
		pos.odd_col   = col_q[0];
		pos.odd_row   = row_q[0];
		pos.idx       = col_q[COL_W-1:1];
		pos.plane_end = ({1'b0, col_q[COL_W-1:1]} == (cpairs - COL_W'(1)))
			&& ({1'b0, row_q[COL_W-1:1]} == (rpairs - COL_W'(1)));
		pos.all_end   = pos.plane_end && plane_wrap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= DIM_W'(28);
			rows_q   <= DIM_W'(28);
			planes_q <= PLANE_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_COLS: cols_q   <= cfg_data[DIM_W-1:0];
				REG_IMAGE_ROWS: rows_q   <= cfg_data[DIM_W-1:0];
				REG_NUM_PLANES: planes_q <= cfg_data[PLANE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			plane_q <= '0;
		end else if (advance) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q   <= '0;
					plane_q <= plane_wrap ? '0 : plane_q + PLANE_W'(1);
				end else begin
					row_q <= row_q + COL_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

### rtl/core/max_pool_2x2_stride2_top.sv
// 2x2 stride-2 max pooling over raster-order planes, top level
//
//  channel   dir  contents
//  s_axis    in   tdata = pixel
//  m_axis    out  tdata = max_value, tlast = plane_end, tuser = all_end
//  cfg       in   cfg_we / cfg_index / cfg_data, 0 cols, 1 rows, 2 planes
//
//  one pixel per cycle unless a result stalls; results are registered after the input stage
//  stages: input register with line store read, then result register
//  a stalled result holds the result stage and a full input stage; s_axis_tready drops only then
//  reset clears counters, valids and the pair maximum, registers go to 28, 28, 1
`timescale 1ns / 1ps
module max_pool_2x2_stride2_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [mp2_pkg::DATA_BITS-1:0]  s_axis_tdata,   // pixel
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [mp2_pkg::DATA_BITS-1:0]  m_axis_tdata,   // max_value
	output logic                          m_axis_tlast,
	output logic                          m_axis_tuser,   // all_end
	input  logic                          cfg_we,
	input  logic [mp2_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mp2_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mp2_pkg::*;

	pos_t  pos;
	logic  accept, out_free, move;

	logic  valid_s1;
	data_t pixel_s1;
	data_t line_rd_s1;
	pos_t  pos_s1;

	data_t pair_max_q;
	data_t line_mem [LINE_DEPTH];
	data_t pair_m;

	logic  out_valid_q;
	data_t out_data_q;
	logic  out_last_q, out_user_q;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign move          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	mp2_pos u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.pos       (pos)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1   <= s_axis_tdata;
			pos_s1     <= pos;
			line_rd_s1 <= line_mem[pos.idx];
		end
	end

	assign pair_m = smax(pair_max_q, pixel_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pair_max_q <= '0;
		else if (move && pos_s1.active && !pos_s1.odd_col)
			pair_max_q <= pixel_s1;
	end

	// line store, even rows write pair maxima
	always_ff @(posedge clk) begin
		if (move && pos_s1.active && pos_s1.odd_col && !pos_s1.odd_row)
			line_mem[pos_s1.idx] <= pair_m;
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= valid_s1 && pos_s1.active && pos_s1.odd_col && pos_s1.odd_row;
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_data_q <= smax(line_rd_s1, pair_m);
			out_last_q <= pos_s1.plane_end;
			out_user_q <= pos_s1.all_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_user_q;

endmodule

### rtl/core/mp2_chk.sv
// port checker for the max pooling top level, with its bind
`timescale 1ns / 1ps
module mp2_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [mp2_pkg::DATA_BITS-1:0] m_axis_tdata,
	input logic                         m_axis_tlast,
	input logic                         m_axis_tuser
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// end of set is always an end of plane
	a_all_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("all_end without plane_end");

	// an empty result register never blocks requests
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// a result does not rise straight out of reset
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(!arst_n))
		else $error("result right after reset");

endmodule

bind max_pool_2x2_stride2_top mp2_chk u_mp2_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
